[rtl/qec_pkg.sv]
// Shared types and constants for the quadrature encoder counter unit.
// Used by qec_core and quadrature_encoder_counter_unit; no dependencies.
`default_nettype none

package qec_pkg;

   // Widths of the count datapath and the register port
   localparam int CountWidth = 32;
   localparam int HistWidth  = 4;
   localparam int AddrWidth  = 4;

   // Event codes carried by the opcode field; code 3 is unused and ignored
   typedef enum logic [1:0] {
      OP_EDGE_A = 2'd0,
      OP_EDGE_B = 2'd1,
      OP_LOAD   = 2'd2
   } opcode_type;

   // Channel of the last accepted edge
   typedef enum logic [1:0] {
      CH_NONE = 2'd0,
      CH_A    = 2'd1,
      CH_B    = 2'd2
   } chan_type;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_STEP  = 2'd0,
      REG_LOWER = 2'd1,
      REG_UPPER = 2'd2
   } reg_index_type;

   // Reset values of the configuration registers
   localparam logic [CountWidth-1:0] StepReset  = 32'h0000_0001;
   localparam logic [CountWidth-1:0] LowerReset = 32'h8000_0000;
   localparam logic [CountWidth-1:0] UpperReset = 32'h7FFF_FFFF;

   // History patterns that mark a full detent
   localparam logic [HistWidth-1:0] HistUp   = 4'h4;
   localparam logic [HistWidth-1:0] HistDown = 4'h8;

   // One input word as the core sees it
   typedef struct packed {
      logic [1:0]                   opcode;
      logic                         other_level;
      logic signed [CountWidth-1:0] load_data;
   } event_type;

   // Configuration values handed to the core
   typedef struct packed {
      logic signed [CountWidth-1:0] step_size;
      logic signed [CountWidth-1:0] lower_limit;
      logic signed [CountWidth-1:0] upper_limit;
   } limits_type;

endpackage

`default_nettype wire

[rtl/qec_core.sv]
// Count state, edge history and bounce filter of the encoder counter.
// Depends on qec_pkg; produces the count that follows each accepted word.
`default_nettype none

module qec_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   take,
   input  wire qec_pkg::event_type                     req_word,
   input  wire qec_pkg::limits_type                    limits,
   output logic signed [qec_pkg::CountWidth-1:0]       next_count
);

   logic signed [qec_pkg::CountWidth-1:0] count_ff, count_in;
   logic [qec_pkg::HistWidth-1:0]         hist_ff, hist_in;
   qec_pkg::chan_type                     last_ff, last_in;

   // Two guard bits keep count +/- step exact before the clamp
   logic signed [qec_pkg::CountWidth+1:0] cnt_ext, step_ext, low_ext, up_ext;
   logic signed [qec_pkg::CountWidth+1:0] sum, clamped;
   logic [qec_pkg::HistWidth-1:0]         hist_a, hist_b;
   logic                                  edge_ok;

   assign cnt_ext  = {{2{count_ff[qec_pkg::CountWidth-1]}}, count_ff};
   assign step_ext = {{2{limits.step_size[qec_pkg::CountWidth-1]}}, limits.step_size};
   assign low_ext  = {{2{limits.lower_limit[qec_pkg::CountWidth-1]}}, limits.lower_limit};
   assign up_ext   = {{2{limits.upper_limit[qec_pkg::CountWidth-1]}}, limits.upper_limit};

   // History after an A edge (level at bit 1) or a B edge (level at bit 0)
   assign hist_a = {hist_ff[1:0], req_word.other_level, 1'b0};
   assign hist_b = {hist_ff[1:0], 1'b0, req_word.other_level};

   // Next state for the presented word
   always_comb begin
      count_in = count_ff;
      hist_in  = hist_ff;
      last_in  = last_ff;
      edge_ok  = 1'b0;
      sum      = cnt_ext;
      case (req_word.opcode)
         qec_pkg::OP_EDGE_A: begin
            if (last_ff != qec_pkg::CH_A) begin
               edge_ok = 1'b1;
               hist_in = hist_a;
               last_in = qec_pkg::CH_A;
               if (hist_a == qec_pkg::HistUp) sum = cnt_ext + step_ext;
            end
         end
         qec_pkg::OP_EDGE_B: begin
            if (last_ff != qec_pkg::CH_B) begin
               edge_ok = 1'b1;
               hist_in = hist_b;
               last_in = qec_pkg::CH_B;
               if (hist_b == qec_pkg::HistDown) sum = cnt_ext - step_ext;
            end
         end
         qec_pkg::OP_LOAD: begin
            count_in = req_word.load_data;
         end
         default: begin
         end
      endcase

      // Clamp to upper, then lower, so lower wins when the limits cross
      clamped = sum;
      if (clamped > up_ext)  clamped = up_ext;
      if (clamped < low_ext) clamped = low_ext;
      if (edge_ok) count_in = clamped[qec_pkg::CountWidth-1:0];
   end

   assign next_count = count_in;

   // State registers, updated only when a word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hist_ff  <= '0;
         last_ff  <= qec_pkg::CH_NONE;
      end else if (take) begin
         count_ff <= count_in;
         hist_ff  <= hist_in;
         last_ff  <= last_in;
      end
   end

   // A load sets the count verbatim
   a_load_sets: assert property (@(posedge clock) disable iff (reset)
      take && req_word.opcode == qec_pkg::OP_LOAD |=> count_ff == $past(req_word.load_data))
      else $error("load did not set count");

   // An A edge right after an accepted A edge changes neither count nor history
   a_bounce_hold: assert property (@(posedge clock) disable iff (reset)
      take && req_word.opcode == qec_pkg::OP_EDGE_A && last_ff == qec_pkg::CH_A
      |=> $stable(count_ff) && $stable(hist_ff))
      else $error("bounced edge changed state");

   // State holds while no word is taken
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(count_ff) && $stable(hist_ff) && $stable(last_ff))
      else $error("state changed without a word");

endmodule

`default_nettype wire

[rtl/quadrature_encoder_counter_unit.sv]
// Top level of the quadrature encoder counter: register port, input and
// result handshakes, result register with skid stage. Depends on qec_pkg, qec_core.
`default_nettype none

// Counts detents from rising-edge events of an encoder's A and B channels,
// with bounce rejection, a signed step and clamp limits; a load word sets the
// count directly. Every word yields one result word carrying the count after
// it. A word is taken in every cycle in which the skid register is empty; its result
// is registered: the count update is a single add and clamp between the count register
// and the result or skid register. A skid register holds one result while rsp_stall is
// high; req_stall is raised only while that skid register is full. Registers:
// step_size at 0x0, lower_limit at 0x4, upper_limit at 0x8; write them while idle.
module quadrature_encoder_counter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic                                req_other_level,
   input  wire logic signed [qec_pkg::CountWidth-1:0] req_load_data,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [qec_pkg::CountWidth-1:0]    rsp_count,
   // register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [qec_pkg::AddrWidth-1:0]       csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   qec_pkg::limits_type limits_ff;
   qec_pkg::event_type  req_word;
   logic signed [qec_pkg::CountWidth-1:0] next_count;
   logic signed [qec_pkg::CountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic signed [qec_pkg::CountWidth-1:0] skid_count_ff, skid_count_in;
   logic rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic req_take, out_free, csr_write;
   logic [1:0] csr_index;

   // Register port: always ready, word index from address bits [3:2]
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.step_size   <= qec_pkg::StepReset;
         limits_ff.lower_limit <= qec_pkg::LowerReset;
         limits_ff.upper_limit <= qec_pkg::UpperReset;
      end else if (csr_write) begin
         unique case (csr_index)
            qec_pkg::REG_STEP:  limits_ff.step_size   <= csr_pwdata;
            qec_pkg::REG_LOWER: limits_ff.lower_limit <= csr_pwdata;
            qec_pkg::REG_UPPER: limits_ff.upper_limit <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         qec_pkg::REG_STEP:  csr_prdata = limits_ff.step_size;
         qec_pkg::REG_LOWER: csr_prdata = limits_ff.lower_limit;
         qec_pkg::REG_UPPER: csr_prdata = limits_ff.upper_limit;
         default:            csr_prdata = '0;
      endcase
   end

   // Input word and count update
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign req_word  = '{opcode: req_opcode, other_level: req_other_level,
                        load_data: req_load_data};

   qec_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (req_take),
      .req_word   (req_word),
      .limits     (limits_ff),
      .next_count (next_count)
   );

   // Result register with one skid word behind it
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      skid_valid_in = skid_valid_ff;
      skid_count_in = skid_count_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_count_in  = skid_count_ff;
            skid_valid_in = 1'b0;
         end else if (req_take) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = next_count;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_count_in = next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      rsp_count_ff  <= rsp_count_in;
      skid_count_ff <= skid_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   // Skid word only exists behind a held result word
   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without result word");

   // A word taken while the result is held must land in the skid register
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      req_take && rsp_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("word lost while result stalled");

   // Reset empties both result stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !skid_valid_ff)
      else $error("result stages not empty after reset");

endmodule

`default_nettype wire
